// ===== rtl/kst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges    = 256;
	localparam int WeightBits  = 32;
	localparam int VBits       = 6;
	localparam int EBits       = 8;
	localparam int CntBits     = 9;

	typedef struct packed {
		logic [VBits-1:0]      from_v;
		logic [VBits-1:0]      to_v;
		logic [WeightBits-1:0] weight;
	} edge_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT,
		ST_INIT,
		ST_READ,
		ST_LOOK,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/kst_sort_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one sorter slot; shifts in from the left on insert, from the right on pop
module kst_sort_cell import kst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        clear,
	input  wire logic        ins_en,
	input  wire edge_t       ins_edge,
	input  wire logic        left_valid,
	input  wire edge_t       left_edge,
	input  wire logic        left_shift,
	input  wire logic        shift_en,
	input  wire edge_t       right_edge,
	output logic             valid,
	output edge_t            cell_edge,
	output logic             shift_out
);
	logic  valid_q;
	edge_t edge_q;
	logic  greater;
	logic  take;
	// strictly greater, so equal weights keep arrival order
	assign greater   = valid_q && (edge_q.weight > ins_edge.weight);
	// an empty cell fills only next to the last occupied one, or at the head of an empty row
	assign take      = greater || (!valid_q && left_valid);
	assign shift_out = ins_en && greater;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (ins_en && take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en && take) begin
			edge_q <= left_shift ? left_edge : ins_edge;
		end else if (shift_en) begin
			edge_q <= right_edge;
		end
	end

	assign valid     = valid_q;
	assign cell_edge = edge_q;
endmodule
`default_nettype wire

// ===== rtl/kst_label_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one vertex label; relabels itself when it matches the merged component
module kst_label_cell import kst_pkg::*; (
	input  wire logic             clk,
	input  wire logic [VBits-1:0] own_index,
	input  wire logic             init,
	input  wire logic             merge,
	input  wire logic [VBits-1:0] old_label,
	input  wire logic [VBits-1:0] new_label,
	output logic [VBits-1:0]      label
);
	logic [VBits-1:0] label_q;
	always_ff @(posedge clk) begin
		if (init) begin
			label_q <= own_index;
		end else if (merge && label_q == old_label) begin
			label_q <= new_label;
		end
	end
	assign label = label_q;
endmodule
`default_nettype wire

// ===== rtl/kruskal_spanning_tree_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// kruskal minimum spanning tree engine
// input channel (in_valid/in_ready): one edge per transaction with from_vertex,
//   to_vertex, edge_weight and final_edge; final_edge starts the run
// edges are kept sorted while they arrive: each lands in a row of 256 sort
//   cells by a parallel compare and one-place shift, one edge per cycle;
//   an edge that arrives with the row full is dropped
// the run walks the sorted row, each edge in decide, read and label compare
//   and merge steps, over a row of 64 label cells that all relabel at once
// a kept edge is held back until the next one is kept or the walk ends, so
//   last_result is known when its transaction goes out
// output channel (out_valid/out_ready): kept edges in ascending weight order,
//   last_result on the final one; one found=0 transaction if none was kept
// the last transaction is offered once the walk ends, after every earlier
//   kept edge is handed out; in_ready returns the cycle after the last
//   transaction is taken
// a stalled receiver holds the walk; no edge is taken during a run
// reset: vertex_count returns to 64, the store empties, outputs go idle
// cfg_we/cfg_data write vertex_count; write only while idle, not enforced
module kruskal_spanning_tree_core import kst_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [6:0]            cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VBits-1:0]      from_vertex,
	input  wire logic [VBits-1:0]      to_vertex,
	input  wire logic [WeightBits-1:0] edge_weight,
	input  wire logic                  final_edge,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [VBits-1:0]           tree_from,
	output logic [VBits-1:0]           tree_to,
	output logic [WeightBits-1:0]      tree_weight,
	output logic                       found,
	output logic                       last_result
);
	state_t state_q, state_d;
	logic [6:0]         vcount_q;
	logic [CntBits-1:0] total_q, idx_q;
	logic [VBits:0]     kept_q, limit;
	edge_t              ins_edge, cur_q, pend_q, out_q;
	logic [VBits-1:0]   la_q, lb_q;
	logic               accept, ins_en, clear, shift_en, merge, init, keep, more;
	logic               pend_valid_q, out_valid_q, out_found_q, out_last_q;

	logic  [MaxEdges-1:0] cvalid, cshift;
	edge_t                cedge [MaxEdges];
	logic  [VBits-1:0]    lab [MaxVertices];

	assign accept   = in_valid && in_ready;
	assign ins_edge = '{from_v: from_vertex, to_v: to_vertex, weight: edge_weight};
	assign ins_en   = accept && (total_q < CntBits'(MaxEdges));
	assign keep     = (la_q != lb_q);
	assign limit    = (vcount_q == 7'd0) ? '0 :
		(vcount_q > 7'(MaxVertices)) ? 7'(MaxVertices - 1) : vcount_q - 7'd1;
	// more edges to examine and room for more kept edges
	assign more     = (idx_q < total_q) && (kept_q < limit);

	for (genvar i = 0; i < MaxEdges; i++) begin : g_sort
		kst_sort_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clear(clear),
			.ins_en(ins_en), .ins_edge(ins_edge),
			.left_valid((i == 0) ? 1'b1 : cvalid[(i == 0) ? 0 : i-1]),
			.left_edge(cedge[(i == 0) ? 0 : i-1]),
			.left_shift((i == 0) ? 1'b0 : cshift[(i == 0) ? 0 : i-1]),
			.shift_en(shift_en),
			.right_edge(cedge[(i == MaxEdges-1) ? i : i+1]),
			.valid(cvalid[i]), .cell_edge(cedge[i]), .shift_out(cshift[i])
		);
	end

	for (genvar v = 0; v < MaxVertices; v++) begin : g_label
		kst_label_cell u_lab (
			.clk(clk), .own_index(VBits'(v)), .init(init), .merge(merge),
			.old_label(lb_q), .new_label(la_q), .label(lab[v])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (accept && final_edge) state_d = ST_SORT;
			ST_SORT: state_d = ST_INIT;
			ST_INIT: state_d = more ? ST_READ : ST_EMIT;
			ST_READ: state_d = ST_LOOK;
			ST_LOOK: state_d = (keep && pend_valid_q) ? ST_EMIT : ST_INIT;
			ST_EMIT: if (out_ready) state_d = out_last_q ? ST_LOAD : ST_INIT;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_LOAD);
		// labels start from the vertex index once the row is complete
		init     = (state_q == ST_SORT);
		// walk pops the head of the row, shifting entries left
		shift_en = (state_q == ST_READ);
		merge    = (state_q == ST_LOOK) && keep;
		// row empties once the last transaction of the run is taken
		clear    = (state_q == ST_EMIT) && out_ready && out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			vcount_q     <= 7'd64;
			total_q      <= '0;
			idx_q        <= '0;
			kept_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_found_q  <= 1'b0;
			out_last_q   <= 1'b0;
			out_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) vcount_q <= cfg_data;
			case (state_q)
				ST_LOAD: if (ins_en) total_q <= total_q + CntBits'(1);
				ST_SORT: begin
					idx_q        <= '0;
					kept_q       <= '0;
					pend_valid_q <= 1'b0;
				end
				// walk over: the held edge, or the empty marker, is the last
				ST_INIT: if (!more) begin
					out_q       <= pend_valid_q ? pend_q : '0;
					out_found_q <= pend_valid_q;
					out_last_q  <= 1'b1;
					out_valid_q <= 1'b1;
				end
				ST_READ: idx_q <= idx_q + CntBits'(1);
				// a new kept edge releases the one held before it
				ST_LOOK: if (keep) begin
					kept_q       <= kept_q + 7'd1;
					pend_valid_q <= 1'b1;
					if (pend_valid_q) begin
						out_q       <= pend_q;
						out_found_q <= 1'b1;
						out_last_q  <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				ST_EMIT: if (out_ready) begin
					out_valid_q <= 1'b0;
					if (out_last_q) total_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			cur_q <= cedge[0];
			la_q  <= lab[cedge[0].from_v];
			lb_q  <= lab[cedge[0].to_v];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK && keep) pend_q <= cur_q;
	end

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign tree_from   = out_q.from_v;
	assign tree_to     = out_q.to_v;
	assign tree_weight = out_q.weight;
	assign last_result = out_last_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid &&
		$stable({tree_from, tree_to, tree_weight, found, last_result})))
		else $error("result changed while stalled");
	a_no_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !in_ready) else $error("input taken during run");
	a_kept_limit: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= 7'(MaxVertices - 1)) else $error("kept count overflow");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> last_result) else $error("empty result not last");
endmodule
`default_nettype wire

// ===== tb/sv/tb_kruskal_spanning_tree_core.sv =====
`timescale 1ns / 1ps
module tb_kruskal_spanning_tree_core;
	import kst_pkg::*;

	// one expected tree edge transaction
	typedef struct {
		logic [VBits-1:0]      t_from;
		logic [VBits-1:0]      t_to;
		logic [WeightBits-1:0] t_weight;
		logic                  t_found;
		logic                  t_last;
	} tree_edge_t;

	int n_errors = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		n_errors++;
	endtask

	// spanning tree predictor plus queue of expected tree edges
	class mst_scoreboard;
		edge_t            graph_edges[$];
		int unsigned      vcount = 64;
		tree_edge_t       pending[$];

		function void note_edge(edge_t e, logic fin);
			int unsigned limit, kept, a, b;
			int          order[$];
			logic [VBits-1:0] lbl[MaxVertices];
			tree_edge_t  t;
			if (graph_edges.size() < MaxEdges)
				graph_edges.insert(graph_edges.size(), e);
			if (!fin)
				return;
			limit = (vcount > MaxVertices) ? MaxVertices : vcount;
			limit = (limit == 0) ? 0 : limit - 1;
			for (int v = 0; v < MaxVertices; v++)
				lbl[v] = v[VBits-1:0];
			// stable ordering by weight: insertion keeps arrival order on ties
			for (int i = 0; i < graph_edges.size(); i++) begin
				int j;
				j = order.size();
				while (j > 0 && graph_edges[order[j-1]].weight > graph_edges[i].weight)
					j--;
				order.insert(j, i);
			end
			kept = 0;
			for (int i = 0; i < order.size() && kept < limit; i++) begin
				edge_t ce;
				ce = graph_edges[order[i]];
				a = lbl[ce.from_v];
				b = lbl[ce.to_v];
				if (a == b)
					continue;
				for (int v = 0; v < MaxVertices; v++)
					if (lbl[v] == b)
						lbl[v] = a[VBits-1:0];
				t.t_from = ce.from_v;
				t.t_to = ce.to_v;
				t.t_weight = ce.weight;
				t.t_found = 1'b1;
				t.t_last = 1'b0;
				pending.insert(pending.size(), t);
				kept++;
			end
			if (kept == 0) begin
				t = '{default: '0};
				t.t_last = 1'b1;
				pending.insert(pending.size(), t);
			end else begin
				pending[pending.size()-1].t_last = 1'b1;
			end
			graph_edges.delete();
		endfunction

		task check_tree_edge(tree_edge_t got);
			tree_edge_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result transaction");
				return;
			end
			want = pending.pop_front();
			if (got.t_from !== want.t_from)
				report_mismatch($sformatf("tree_from %0d want %0d", got.t_from, want.t_from));
			if (got.t_to !== want.t_to)
				report_mismatch($sformatf("tree_to %0d want %0d", got.t_to, want.t_to));
			if (got.t_weight !== want.t_weight)
				report_mismatch($sformatf("tree_weight %0h want %0h",
					got.t_weight, want.t_weight));
			if (got.t_found !== want.t_found)
				report_mismatch($sformatf("found %0b want %0b", got.t_found, want.t_found));
			if (got.t_last !== want.t_last)
				report_mismatch($sformatf("last_result %0b want %0b", got.t_last, want.t_last));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [6:0]            cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [VBits-1:0]      from_vertex = '0;
	logic [VBits-1:0]      to_vertex = '0;
	logic [WeightBits-1:0] edge_weight = '0;
	logic                  final_edge = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [VBits-1:0]      tree_from;
	logic [VBits-1:0]      tree_to;
	logic [WeightBits-1:0] tree_weight;
	logic                  found;
	logic                  last_result;

	mst_scoreboard sb = new();
	int  idle_cycles = 0;
	bit  rx_stall_on = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	kruskal_spanning_tree_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.from_vertex(from_vertex), .to_vertex(to_vertex),
		.edge_weight(edge_weight), .final_edge(final_edge),
		.out_valid(out_valid), .out_ready(out_ready),
		.tree_from(tree_from), .tree_to(tree_to), .tree_weight(tree_weight),
		.found(found), .last_result(last_result)
	);

	// receiver drops out_ready at random while rx_stall_on is set, else stays ready
	always @(posedge clk) begin
		if (!rx_stall_on)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// result side: compare each accepted transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_tree_edge('{tree_from, tree_to, tree_weight, found, last_result});
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// drive one edge transaction and wait for its acceptance
	task automatic send_edge(input logic [5:0] fv, input logic [5:0] tv,
			input logic [31:0] w, input logic fin);
		edge_t e;
		e.from_v = fv;
		e.to_v = tv;
		e.weight = w;
		in_valid <= 1'b1;
		from_vertex <= fv;
		to_vertex <= tv;
		edge_weight <= w;
		final_edge <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_edge(e, fin);
	endtask

	// random gap between bursts; valid dropped only when not sending next
	task automatic sender_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		final_edge <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [6:0] vc);
		cfg_we <= 1'b1;
		cfg_data <= vc;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.vcount = vc;
	endtask

	// random graph: random endpoints up to vmax, some self loops, some endpoints anywhere in 0..63
	task automatic random_graph(input int n_edges, input int vmax);
		logic [5:0] a, b;
		logic [31:0] w;
		for (int i = 0; i < n_edges; i++) begin
			a = 6'($urandom_range(0, vmax));
			b = ($urandom_range(0, 3) == 0) ? a : 6'($urandom_range(0, vmax));
			if ($urandom_range(0, 3) == 0)
				b = 6'($urandom_range(0, 63));
			w = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 7);
			send_edge(a, b, w, i == n_edges - 1);
			sender_gap();
		end
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single self loop gives the no-edge result
		send_edge(6'd5, 6'd5, 32'd9, 1'b1);
		drain_results();
		// extremes of fields, ties keep arrival order, loop closure skipped
		send_edge(6'd0, 6'd63, 32'hFFFF_FFFF, 1'b0);
		send_edge(6'd63, 6'd1, 32'd0, 1'b0);
		send_edge(6'd1, 6'd2, 32'd7, 1'b0);
		send_edge(6'd2, 6'd3, 32'd7, 1'b0);
		send_edge(6'd3, 6'd1, 32'd7, 1'b0);
		send_edge(6'd42, 6'd21, 32'hAAAA_5555, 1'b1);
		drain_results();
		// vertex count zero keeps nothing
		write_vertex_count(7'd0);
		send_edge(6'd1, 6'd2, 32'd3, 1'b0);
		send_edge(6'd2, 6'd4, 32'd1, 1'b1);
		drain_results();
		// vertex count 2 stops after one edge; indices above count still usable
		write_vertex_count(7'd2);
		send_edge(6'd10, 6'd20, 32'd3, 1'b0);
		send_edge(6'd30, 6'd40, 32'd1, 1'b1);
		drain_results();
		// above the vertex limit is clamped
		write_vertex_count(7'd127);
		send_edge(6'd7, 6'd8, 32'h8000_0000, 1'b1);
		drain_results();

		// random phases over several settings
		write_vertex_count(7'd64);
		random_graph(30, 63);
		rx_stall_on = 1'b0;
		write_vertex_count(7'd5);
		random_graph(12, 7);
		rx_stall_on = 1'b1;
		write_vertex_count(7'd1);
		random_graph(4, 3);
		write_vertex_count(7'd16);
		random_graph(25, 15);
		write_vertex_count(7'd64);
		random_graph(27, 63);
		write_vertex_count(7'd8);
		random_graph(20, 9);
		repeat (20) @(posedge clk);

		if (n_errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== kruskal_spanning_tree_core.f =====
rtl/kst_pkg.sv
rtl/kst_sort_cell.sv
rtl/kst_label_cell.sv
rtl/kruskal_spanning_tree_core.sv
tb/sv/tb_kruskal_spanning_tree_core.sv
